// File: hw/rtl/dqps_pkg.sv
`default_nettype none

package dqps_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_QUERY      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int PRICE_TOTAL_W = 36;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [9:0]          item_code;
    logic signed [31:0]  item_price;
    logic signed [31:0]  item_quantity;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [9:0]          popped_code;
    logic signed [31:0]  popped_price;
    logic signed [31:0]  popped_quantity;
    logic signed [31:0]  highest_price;
    logic signed [31:0]  lowest_price;
    logic signed [35:0]  price_total;
    logic [4:0]          entry_count;
    logic signed [63:0]  value_total;
  } out_word_t;

  // one stored record
  typedef struct packed {
    logic [9:0]          code;
    logic signed [31:0]  price;
    logic signed [31:0]  qty;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic issue;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic query_go;
    logic walk_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/dqps_ctrl.sv
`default_nettype none

module dqps_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dqps_pkg::sts_t sts,
  output dqps_pkg::cmd_t     cmd
);
  import dqps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.query_go ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (sts.walk_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/dqps_dpath.sv
`default_nettype none

module dqps_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dqps_pkg::in_word_t in_data,
  input  wire dqps_pkg::cmd_t     cmd,
  output dqps_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dqps_pkg::out_word_t     out_data
);
  import dqps_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = AW + 1;
  localparam int PW  = 32 + CW;
  localparam int PAW = (PW > PRICE_TOTAL_W) ? PW : PRICE_TOTAL_W;

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic signed [PAW-1:0] P36_MAX = PAW'(64'sd34359738367);
  localparam logic signed [PAW-1:0] P36_MIN = PAW'(-64'sd34359738368);
  localparam logic signed [63:0]    V_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0]    V_MIN   = 64'sh8000_0000_0000_0000;

  // storage
  entry_t              mem [DEPTH];
  entry_t              rd_data_r;

  // request and ring state
  in_word_t            req_r;
  logic [AW-1:0]       front_r;
  logic [CW-1:0]       count_r;

  // result flags
  logic [1:0]          status_r;
  logic                res_pop_r;
  logic                res_qry_r;
  logic                res_empty_r;

  // walk pipeline
  logic [CW-1:0]       walk_k_r;
  logic                rd_vld_r;
  logic                prod_vld_r;
  logic signed [63:0]  prod_r;
  logic signed [31:0]  hi_r;
  logic signed [31:0]  lo_r;
  logic signed [PAW-1:0] ptot_r;
  logic signed [63:0]  vtot_r;

  logic                out_valid_r;
  out_word_t           out_data_r;
  out_word_t           out_data_nxt;

  // decode
  logic                is_push, is_pop, is_query, is_front, full, empty;
  logic [AW-1:0]       front_inc, front_dec;
  logic [SW-1:0]       back_sum, last_sum, walk_sum;
  logic [AW-1:0]       back_slot, last_slot, walk_slot;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic signed [64:0]  vsum;
  logic signed [PAW-1:0] ptot_sat;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return t[AW-1:0];
  endfunction

  always_comb begin
    is_push  = (req_r.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK});
    is_pop   = (req_r.req_type inside {REQ_POP_FRONT, REQ_POP_BACK});
    is_query = (req_r.req_type == REQ_QUERY);
    is_front = (req_r.req_type inside {REQ_PUSH_FRONT, REQ_POP_FRONT});
    full     = (count_r >= DEPTH_C);
    empty    = (count_r == '0);

    front_inc = (front_r == LAST_A) ? '0 : front_r + AW'(1);
    front_dec = (front_r == '0) ? LAST_A : front_r - AW'(1);

    back_sum  = SW'(front_r) + SW'(count_r);
    last_sum  = back_sum - SW'(1);
    walk_sum  = SW'(front_r) + SW'(walk_k_r);
    back_slot = wrap(back_sum);
    last_slot = wrap(last_sum);
    walk_slot = wrap(walk_sum);

    wr_en   = cmd.exec && is_push && !full;
    wr_addr = is_front ? front_dec : back_slot;
    rd_en   = (cmd.exec && is_pop && !empty) || cmd.issue;
    rd_addr = cmd.issue ? walk_slot : (is_front ? front_r : last_slot);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{code: req_r.item_code, price: req_r.item_price,
                        qty: req_r.item_quantity};
    end
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      if (is_push && !full) begin
        if (is_front) front_r <= front_dec;
        count_r <= count_r + CW'(1);
      end else if (is_pop && !empty) begin
        if (is_front) front_r <= front_inc;
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.exec) begin
      res_pop_r   <= is_pop && !empty;
      res_qry_r   <= is_query;
      res_empty_r <= empty;
      if (is_push && full)                status_r <= ST_FULL;
      else if ((is_pop || is_query) && empty) status_r <= ST_EMPTY;
      else                                status_r <= ST_OK;
    end
  end

  // statistics walk
  always_comb begin
    vsum = {vtot_r[63], vtot_r} + {prod_r[63], prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      walk_k_r <= '0;
      hi_r     <= 32'sh8000_0000;
      lo_r     <= 32'sh7FFF_FFFF;
      ptot_r   <= '0;
      vtot_r   <= '0;
    end else begin
      if (cmd.issue) walk_k_r <= walk_k_r + CW'(1);
      if (rd_vld_r) begin
        if (rd_data_r.price > hi_r) hi_r <= rd_data_r.price;
        if (rd_data_r.price < lo_r) lo_r <= rd_data_r.price;
        ptot_r <= ptot_r + PAW'(rd_data_r.price);
        prod_r <= rd_data_r.price * rd_data_r.qty;
      end
      if (prod_vld_r) begin
        if (vsum[64] != vsum[63]) vtot_r <= vsum[64] ? V_MIN : V_MAX;
        else                      vtot_r <= vsum[63:0];
      end
    end
  end

  // output word
  always_comb begin
    if (ptot_r > P36_MAX)      ptot_sat = P36_MAX;
    else if (ptot_r < P36_MIN) ptot_sat = P36_MIN;
    else                       ptot_sat = ptot_r;
  end

  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt.status      = status_r;
    out_data_nxt.entry_count = 5'(count_r);
    if (res_pop_r) begin
      out_data_nxt.popped_code     = rd_data_r.code;
      out_data_nxt.popped_price    = rd_data_r.price;
      out_data_nxt.popped_quantity = rd_data_r.qty;
    end
    if (res_qry_r) begin
      if (res_empty_r) begin
        out_data_nxt.highest_price = '1;
        out_data_nxt.lowest_price  = '1;
        out_data_nxt.price_total   = '1;
        out_data_nxt.value_total   = '1;
      end else begin
        out_data_nxt.highest_price = hi_r;
        out_data_nxt.lowest_price  = lo_r;
        out_data_nxt.price_total   = ptot_sat[PRICE_TOTAL_W-1:0];
        out_data_nxt.value_total   = vtot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.query_go  = is_query && !empty;
    sts.walk_last = (walk_k_r == count_r - CW'(1));
    sts.pipe_busy = rd_vld_r || prod_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/deque_with_price_statistics.sv
`default_nettype none

// bounded double-ended queue of item records (code, price, quantity) with
// price statistics. each input word is one request: push front, push back,
// pop front, pop back or query; each request gives exactly one result word.
// a push onto a full store is dropped with status full; a pop or query on an
// empty store gives status empty (a query then returns -1 in all totals).
// a query reports highest and lowest price, the price sum (saturated to 36
// bits), the entry count and the saturating 64-bit sum of quantity * price;
// the mean is left to the user as price_total / entry_count.
// timing: a push, a pop or an unknown request goes from accept through the
// execute and done states to the result; a query on a non-empty store also
// runs the walk and drain states, paced by the single read port of the entry
// memory, which the walk reads one entry per cycle followed by the multiply
// and accumulate stages. a new word is taken once the previous one has been
// placed in the output register, even if that result is still waiting.
// the entry memory needs no clearing after reset; only held entries are read.
module deque_with_price_statistics #(
  parameter int DEPTH = 16          // entries, 1 to 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request words
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dqps_pkg::in_word_t   in_data,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dqps_pkg::out_word_t       out_data
);
  import dqps_pkg::*;

  cmd_t cmd;   // sequencing commands
  sts_t sts;   // datapath status back to the controller

  // state machine: idle, execute, walk, drain, done
  dqps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring memory, pointers, statistics pipeline and output register
  dqps_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
